// ===== src/sorted_set_statistics_defines.svh =====
// assertion helpers shared by the sorted set statistics blocks
`ifndef SORTED_SET_STATISTICS_DEFINES_SVH
`define SORTED_SET_STATISTICS_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SSS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SSS_ASSERT_IMPL(label, ante, cons)
`define SSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/sss_pkg.sv =====
package sss_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int DAT_W       = 8;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W       = 14;
	localparam int DIV_CNT_W   = $clog2(SUM_W);
	localparam int OUT_W       = 5 * DAT_W;

	typedef struct packed {
		logic clear;
		logic insert;
		logic rotate;
		logic div_start;
		logic pop;
	} sss_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic rot_done;
		logic div_busy;
		logic run_end;
	} sss_stat_t;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_START = 4'b0010,
		ST_SEEK  = 4'b0100,
		ST_EMIT  = 4'b1000
	} sss_state_t;

endpackage

// ===== src/sorted_set_statistics.sv =====
// loads one sample per cycle while in the load state into a sorted cell row (samples that
// arrive when it is full are dropped); after the transaction with tlast the divider is started,
// then the ring of n cells rotates once while the 14-step divider forms the mean
// results then leave at one per cycle while m_tready is high
// arst_n clears count, sum and control; the cell contents stay undefined
module sorted_set_statistics (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [sss_pkg::DAT_W-1:0]   s_tdata,  // sample
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [sss_pkg::OUT_W-1:0]   m_tdata,  // sorted_value, minimum, maximum, mean, median
	output logic                        m_tlast
);
	import sss_pkg::*;

	sss_cmd_t         cmd;
	sss_stat_t        stat;
	logic [DAT_W-1:0] sorted_value;
	logic [DAT_W-1:0] minimum;
	logic [DAT_W-1:0] maximum;
	logic [DAT_W-1:0] mean;
	logic [DAT_W-1:0] median;

	sss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sss_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.din          (s_tdata),
		.sorted_value (sorted_value),
		.minimum      (minimum),
		.maximum      (maximum),
		.mean         (mean),
		.median       (median)
	);

	assign m_tdata = {median, mean, maximum, minimum, sorted_value};
	assign m_tlast = stat.run_end;

endmodule

// ===== src/sss_div.sv =====
module sss_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sss_pkg::SUM_W-1:0]   dividend,
	input  logic [sss_pkg::CNT_W-1:0]   divisor,
	output logic                        busy,
	output logic [sss_pkg::DAT_W-1:0]   quotient
);
	import sss_pkg::*;

	logic [CNT_W-1:0]     rem_q;
	logic [SUM_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [CNT_W:0]       trial;
	logic [CNT_W:0]       diff;
	logic                 ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(SUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q[DAT_W-1:0];

endmodule

// ===== src/sss_dp.sv =====
`include "sorted_set_statistics_defines.svh"

module sss_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sss_pkg::sss_cmd_t          cmd,
	output sss_pkg::sss_stat_t         stat,
	input  logic [sss_pkg::DAT_W-1:0]  din,
	output logic [sss_pkg::DAT_W-1:0]  sorted_value,
	output logic [sss_pkg::DAT_W-1:0]  minimum,
	output logic [sss_pkg::DAT_W-1:0]  maximum,
	output logic [sss_pkg::DAT_W-1:0]  mean,
	output logic [sss_pkg::DAT_W-1:0]  median
);
	import sss_pkg::*;

	logic [DAT_W-1:0]       cell_q [MAX_SAMPLES];
	logic [MAX_SAMPLES-1:0] le;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;
	logic [SUM_W-1:0]       sum_q;
	logic [DAT_W-1:0]       min_q;
	logic [DAT_W-1:0]       max_q;
	logic [DAT_W-1:0]       med_q;
	logic                   div_busy;
	logic [DAT_W-1:0]       div_q;

	// cells below the count hold the set in ascending order
	always_comb begin
		for (int i = 0; i < MAX_SAMPLES; i++) begin
			le[i] = (CNT_W'(i) < count_q) && (cell_q[i] <= din);
		end
	end

	for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
		logic [DAT_W-1:0] ins_v;
		logic [DAT_W-1:0] up_v;

		if (g == 0) begin : g_first
			assign ins_v = le[0] ? cell_q[0] : din;
		end else begin : g_rest
			assign ins_v = le[g] ? cell_q[g] : (le[g-1] ? din : cell_q[g-1]);
		end

		// rotation closes the ring at the last valid cell
		if (g == MAX_SAMPLES - 1) begin : g_top
			assign up_v = cell_q[0];
		end else begin : g_mid
			assign up_v = (cmd.rotate && (CNT_W'(g + 1) == count_q)) ? cell_q[0] : cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				cell_q[g] <= ins_v;
			end else if (cmd.rotate || cmd.pop) begin
				cell_q[g] <= up_v;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.insert) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(din);
			end else if (cmd.pop) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.rotate) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// head of the ring walks through the sorted set once
	always_ff @(posedge clk) begin
		if (cmd.rotate) begin
			if (idx_q == '0) begin
				min_q <= cell_q[0];
			end
			if (idx_q == (count_q >> 1)) begin
				med_q <= cell_q[0];
			end
			if (idx_q == count_q - 1'b1) begin
				max_q <= cell_q[0];
			end
		end
	end

	sss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (div_q)
	);

	assign stat.full     = count_q == CNT_W'(MAX_SAMPLES);
	assign stat.empty    = count_q == '0;
	assign stat.rot_done = idx_q == count_q;
	assign stat.div_busy = div_busy;
	assign stat.run_end  = count_q == CNT_W'(1);

	assign sorted_value = cell_q[0];
	assign minimum      = min_q;
	assign maximum      = max_q;
	assign mean         = div_q;
	assign median       = med_q;

	`SSS_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CNT_W'(MAX_SAMPLES))
	`SSS_ASSERT_IMPL(a_no_insert_full, cmd.insert, count_q != CNT_W'(MAX_SAMPLES))

endmodule

// ===== src/sss_ctrl.sv =====
`include "sorted_set_statistics_defines.svh"

module sss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tlast,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  sss_pkg::sss_stat_t  stat,
	output sss_pkg::sss_cmd_t   cmd
);
	import sss_pkg::*;

	sss_state_t state_q;
	sss_state_t state_d;
	logic       s_xfer;

	assign s_tready = state_q == ST_LOAD;
	assign m_tvalid = state_q == ST_EMIT;
	assign s_xfer   = s_tvalid && s_tready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			ST_LOAD: begin
				cmd.insert = s_xfer && !stat.full;
				if (s_xfer && s_tlast) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_SEEK;
			end
			ST_SEEK: begin
				cmd.rotate = !stat.rot_done;
				if (stat.rot_done && !stat.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (m_tready) begin
					cmd.pop = 1'b1;
					if (stat.run_end) begin
						cmd.clear = 1'b1;
						state_d   = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	`SSS_ASSERT_IMPL(a_one_side, s_tready, !m_tvalid)
	`SSS_ASSERT_NEXT(a_div_runs, state_q == ST_START, stat.div_busy)
	`SSS_ASSERT_IMPL(a_emit_ready, state_q == ST_EMIT, !stat.div_busy && !stat.empty)
	`SSS_ASSERT_NEXT(a_run_clears, m_tvalid && m_tready && stat.run_end, stat.empty && s_tready)

endmodule
